// File: sv/anv_pkg.sv
// Shared types and constants for the all nearest smaller values block.
`timescale 1ns / 1ps

package anv_pkg;

  localparam int MAX_LEN    = 64;
  localparam int VALUE_BITS = 31;
  localparam int IDX_W      = $clog2(MAX_LEN);
  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  localparam int POS_W      = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  // One classified input transfer as it waits in the queue.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [IDX_W-1:0]      idx;    // slot in the value store
    logic                  store;  // 0: dropped, capacity reached
    logic                  last;
    logic                  ovf;    // overflow seen so far in this sequence
    logic [CNT_W-1:0]      len;    // stored sequence length, including this item if it is stored
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]      idx;
    logic [VALUE_BITS-1:0] val;
  } stk_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_CMP,
    ST_EMIT_RD,
    ST_EMIT_WR
  } st_t;

endpackage

// File: sv/all_nearest_smaller_values.sv
// Top level of the all nearest smaller values block.
`timescale 1ns / 1ps

// Loads a sequence of unsigned 31-bit values, one per input transfer, until a
// transfer with in_tlast high; that transfer's value is the final element. The
// block then returns one result per position in index order, giving the index
// of the nearest strictly smaller value on each side with a found flag (index
// 0 when not found; equal values never count). Up to 64 values are kept; more
// are dropped and every result of that sequence has overflow set. out_tlast
// marks the result for the last position. A front end classifies input
// transfers into a four-entry queue, so input is still accepted while the back
// end works until that queue is full. A sequence is loaded, then solved by two
// stack passes, left then right, each with a start step and then one compare
// step per element or stack pop, then drained by reading both result stores
// and writing one result per position. Each pass pops at most n-1 times for n
// values, and every neighboring pair of values costs at least one pop across
// the two passes.
module all_nearest_smaller_values (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [30:0] value, [31] zero pad
  input  logic [anv_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [5:0] position, [11:6] left_index, [12] left_found, [18:13] right_index,
  // [19] right_found, [20] overflow, [23:21] zero pad
  output logic [anv_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);

  anv_pkg::entry_t push_entry;
  anv_pkg::entry_t q_head;
  logic            q_push, q_full, q_pop, q_empty;

  anv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  anv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  anv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sv/anv_front.sv
// Input front end: counts positions, marks dropped items and overflow.
`timescale 1ns / 1ps

module anv_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [anv_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tlast,
  input  logic                                q_full,
  output logic                                q_push,
  output anv_pkg::entry_t                     q_entry
);

  logic [anv_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      store;
  logic [anv_pkg::CNT_W-1:0] len;
  logic                      ovf_after;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign store     = cnt_r < anv_pkg::CNT_W'(anv_pkg::MAX_LEN);
  assign len       = store ? cnt_r + anv_pkg::CNT_W'(1) : cnt_r;
  assign ovf_after = ovf_r || !store;

  always_comb begin
    q_entry.value = in_tdata[anv_pkg::VALUE_BITS-1:0];
    q_entry.idx   = cnt_r[anv_pkg::IDX_W-1:0];
    q_entry.store = store;
    q_entry.last  = in_tlast;
    q_entry.ovf   = ovf_after;
    q_entry.len   = len;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (q_push) begin
      if (in_tlast) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        cnt_nxt = len;
        ovf_nxt = ovf_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// File: sv/anv_queue.sv
// Short FIFO between the front end and the solver.
`timescale 1ns / 1ps

module anv_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  anv_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output anv_pkg::entry_t head,
  output logic            empty
);

  anv_pkg::entry_t             slots_r [anv_pkg::Q_DEPTH];
  logic [anv_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [anv_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [anv_pkg::Q_PTR_W:0]   count_r, count_nxt;
  logic                        do_push, do_pop;

  assign full    = count_r == (anv_pkg::Q_PTR_W + 1)'(anv_pkg::Q_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + anv_pkg::Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + anv_pkg::Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (anv_pkg::Q_PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (anv_pkg::Q_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: sv/anv_back.sv
// Back end: value store, two stack passes and the result drain.
`timescale 1ns / 1ps

module anv_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  anv_pkg::entry_t                 q_head,
  input  logic                            q_empty,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [anv_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast
);

  localparam int IW = anv_pkg::IDX_W;
  localparam int CW = anv_pkg::CNT_W;
  localparam int VW = anv_pkg::VALUE_BITS;

  // Storage
  logic [VW-1:0]     val_mem  [anv_pkg::MAX_LEN];
  anv_pkg::stk_t     stk_mem  [anv_pkg::MAX_LEN];
  anv_pkg::res_t     lres_mem [anv_pkg::MAX_LEN];
  anv_pkg::res_t     rres_mem [anv_pkg::MAX_LEN];
  logic [VW-1:0]     val_rd_r;
  anv_pkg::stk_t     stk_rd_r;
  anv_pkg::res_t     lres_rd_r, rres_rd_r;

  // Control
  anv_pkg::st_t      state_r, state_nxt;
  logic              dir_r, dir_nxt;          // 0 left pass, 1 right pass
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [IW-1:0]     last_pos_r, last_pos_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     top_r, top_nxt;
  logic              use_rd_r, use_rd_nxt;
  anv_pkg::stk_t     cache_r, cache_nxt;
  logic [IW-1:0]     emit_k_r, emit_k_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [anv_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory ports
  logic              val_we, val_re;
  logic [IW-1:0]     val_waddr, val_raddr;
  logic              stk_we, stk_re;
  logic [IW-1:0]     stk_waddr, stk_raddr;
  anv_pkg::stk_t     stk_wdata;
  logic              lres_we, rres_we, res_re;
  anv_pkg::res_t     res_wdata;

  anv_pkg::stk_t     top_ent;
  logic              has_top, do_pop, out_free, pass_end;

  assign top_ent  = use_rd_r ? stk_rd_r : cache_r;
  assign has_top  = top_r != '0;
  assign do_pop   = has_top && (top_ent.val >= val_rd_r);
  assign out_free = !out_valid_r || out_tready;
  assign pass_end = dir_r ? (pos_r == '0) : (pos_r == last_pos_r);

  always_comb begin
    state_nxt     = state_r;
    dir_nxt       = dir_r;
    pos_nxt       = pos_r;
    last_pos_nxt  = last_pos_r;
    ovf_nxt       = ovf_r;
    top_nxt       = top_r;
    use_rd_nxt    = use_rd_r;
    cache_nxt     = cache_r;
    emit_k_nxt    = emit_k_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    val_we        = 1'b0;
    val_waddr     = q_head.idx;
    val_re        = 1'b0;
    val_raddr     = pos_r;
    stk_we        = 1'b0;
    stk_waddr     = top_r[IW-1:0];
    stk_wdata     = '{idx: pos_r, val: val_rd_r};
    stk_re        = 1'b0;
    stk_raddr     = IW'(top_r - CW'(2));
    lres_we       = 1'b0;
    rres_we       = 1'b0;
    res_re        = 1'b0;
    res_wdata     = '{found: has_top, idx: has_top ? top_ent.idx : '0};

    unique case (state_r)
      anv_pkg::ST_LOAD: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          val_we = q_head.store;
          if (q_head.last) begin
            last_pos_nxt = IW'(q_head.len - CW'(1));
            ovf_nxt      = q_head.ovf;
            dir_nxt      = 1'b0;
            pos_nxt      = '0;
            state_nxt    = anv_pkg::ST_START;
          end
        end
      end
      anv_pkg::ST_START: begin
        val_re     = 1'b1;
        top_nxt    = '0;
        use_rd_nxt = 1'b0;
        state_nxt  = anv_pkg::ST_CMP;
      end
      anv_pkg::ST_CMP: begin
        if (do_pop) begin
          top_nxt    = top_r - CW'(1);
          stk_re     = top_r > CW'(1);
          use_rd_nxt = 1'b1;
        end else begin
          lres_we    = !dir_r;
          rres_we    = dir_r;
          stk_we     = 1'b1;
          cache_nxt  = stk_wdata;
          use_rd_nxt = 1'b0;
          top_nxt    = top_r + CW'(1);
          if (pass_end) begin
            if (!dir_r) begin
              dir_nxt   = 1'b1;
              pos_nxt   = last_pos_r;
              state_nxt = anv_pkg::ST_START;
            end else begin
              emit_k_nxt = '0;
              state_nxt  = anv_pkg::ST_EMIT_RD;
            end
          end else begin
            pos_nxt   = dir_r ? pos_r - IW'(1) : pos_r + IW'(1);
            val_re    = 1'b1;
            val_raddr = pos_nxt;
          end
        end
      end
      anv_pkg::ST_EMIT_RD: begin
        res_re    = 1'b1;
        state_nxt = anv_pkg::ST_EMIT_WR;
      end
      anv_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = emit_k_r == last_pos_r;
          // position, left_index, left_found, right_index, right_found, overflow
          out_data_nxt  = anv_pkg::OUT_DATA_W'({ovf_r,
                                                rres_rd_r.found,
                                                anv_pkg::POS_W'(rres_rd_r.idx),
                                                lres_rd_r.found,
                                                anv_pkg::POS_W'(lres_rd_r.idx),
                                                anv_pkg::POS_W'(emit_k_r)});
          if (emit_k_r == last_pos_r) begin
            state_nxt = anv_pkg::ST_LOAD;
          end else begin
            emit_k_nxt = emit_k_r + IW'(1);
            state_nxt  = anv_pkg::ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = anv_pkg::ST_LOAD;
    endcase
  end

  // Memories, registered reads
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= q_head.value;
    end
    if (val_re) begin
      val_rd_r <= val_mem[val_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (lres_we) begin
      lres_mem[pos_r] <= res_wdata;
    end
    if (res_re) begin
      lres_rd_r <= lres_mem[emit_k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rres_we) begin
      rres_mem[pos_r] <= res_wdata;
    end
    if (res_re) begin
      rres_rd_r <= rres_mem[emit_k_r];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dir_r      <= dir_nxt;
    pos_r      <= pos_nxt;
    last_pos_r <= last_pos_nxt;
    ovf_r      <= ovf_nxt;
    use_rd_r   <= use_rd_nxt;
    cache_r    <= cache_nxt;
    emit_k_r   <= emit_k_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= anv_pkg::ST_LOAD;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
